>>> rtl/nfabm_pkg.sv
`default_nettype none

package nfabm_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int SET_W      = 64;
    localparam int IDX_W      = 6;
    localparam int REQ_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    // Default number of automaton states; legal range is 2 to 64.
    localparam int NUM_STATES_DEF = 64;

    // Request codes carried in req_type.
    localparam logic [REQ_W-1:0] REQ_LOAD_ZERO = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_ONE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LOAD_EPS  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RESTART   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SYMBOL    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [IDX_W-1:0] row_index;
        logic [SET_W-1:0] row_bits;
        logic             symbol;
    } nfabm_in_t;

    typedef struct packed {
        logic             accepted;
        logic [SET_W-1:0] active_set;
    } nfabm_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_CLOSE,
        ST_DONE
    } nfabm_state_t;

endpackage

`default_nettype wire

>>> rtl/nfabm_ram.sv
`default_nettype none

module nfabm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/nfa_bitstream_matcher.sv
`default_nettype none

// NFA bit-stream matcher. The block simulates a nondeterministic automaton with
// epsilon moves over a binary alphabet. Load transactions write one successor
// row (symbol 0, symbol 1 or epsilon) of one state; rows start out empty after
// reset. A restart transaction makes the active set the epsilon closure of the
// start state, and a symbol transaction moves every active state along the
// chosen rows and then closes the result under epsilon moves. Every input
// transaction returns exactly one result transaction with the new active set and
// a flag that is set when any accepting state is active. One transaction is
// worked on at a time. A load, a restart to a state outside the automaton and
// an unused request code need no row reads. A symbol reads the transition row
// of each state active before it, and a symbol or a restart then reads the
// epsilon row of each state in the closed result; the single read port of
// these memories sets the pace, and a state that is only found through the
// epsilon row just read waits for that row to come back. The input is ready
// again once the result register is loaded, even while that result still
// waits.
module nfa_bitstream_matcher
    import nfabm_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire nfabm_in_t             s_data,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output nfabm_out_t                 m_data,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Width of a state number inside the automaton.
    localparam int SW = $clog2(NUM_STATES);
    // The symbol 0 and symbol 1 rows share one memory; the symbol picks the half.
    localparam int TDEPTH = 2 * (1 << SW);
    localparam int N = NUM_STATES;

    nfabm_state_t state_reg, state_next;

    logic [N-1:0]     final_mask_reg;
    logic [IDX_W-1:0] start_reg;

    // cur_reg holds the active set. work_reg is the set of states whose rows
    // still have to be read: the old active set while gathering, and the
    // states not yet expanded while closing under epsilon moves.
    logic [N-1:0] cur_reg,  cur_next;
    logic [N-1:0] work_reg, work_next;
    logic         sym_reg,  sym_next;
    logic         rd_pend_reg;
    logic         rvld_reg, rvld_next;

    // One valid bit per row; a row that was never loaded reads as empty.
    logic [TDEPTH-1:0] trans_vld_reg;
    logic [N-1:0]      eps_vld_reg;

    logic       m_valid_reg, m_valid_next;
    nfabm_out_t m_data_reg,  m_data_next;

    logic           in_fire;
    logic           out_load;
    logic           idx_ok;
    logic           start_ok;
    logic           trans_we;
    logic           eps_we;
    logic [SW:0]    trans_waddr;
    logic [SW:0]    trans_raddr;
    logic [N-1:0]   row_wdata;
    logic [N-1:0]   trans_q;
    logic [N-1:0]   eps_q;
    logic [N-1:0]   rdata;
    logic [N-1:0]   pick_oh;
    logic [SW-1:0]  pick_idx;
    logic           issue;
    logic           work_idle;

    assign in_fire  = s_valid && s_ready;
    assign idx_ok   = {1'b0, s_data.row_index} < (IDX_W + 1)'(N);
    assign start_ok = {1'b0, start_reg} < (IDX_W + 1)'(N);
    assign row_wdata = s_data.row_bits[N-1:0];

    // Row loads are written straight into the memories on acceptance.
    always_comb begin
        trans_we = 1'b0;
        eps_we   = 1'b0;
        case (s_data.req_type) inside
            REQ_LOAD_ZERO, REQ_LOAD_ONE: trans_we = in_fire && idx_ok;
            REQ_LOAD_EPS:                eps_we   = in_fire && idx_ok;
            default: begin
            end
        endcase
    end

    assign trans_waddr = {s_data.req_type == REQ_LOAD_ONE, s_data.row_index[SW-1:0]};

    // The lowest state still waiting is read next.
    assign pick_oh = work_reg & (~work_reg + 1'b1);

    always_comb begin
        pick_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (pick_oh[i]) begin
                pick_idx = pick_idx | SW'(i);
            end
        end
    end

    assign issue = ((state_reg == ST_GATHER) || (state_reg == ST_CLOSE)) && (work_reg != '0);
    assign work_idle = (work_reg == '0) && !rd_pend_reg;
    assign trans_raddr = {sym_reg, pick_idx};

    always_comb begin
        if (state_reg == ST_GATHER) begin
            rvld_next = trans_vld_reg[trans_raddr];
        end else begin
            rvld_next = eps_vld_reg[pick_idx];
        end
    end

    nfabm_ram #(
        .WIDTH (N),
        .DEPTH (TDEPTH)
    ) u_trans_ram (
        .aclk  (aclk),
        .we    (trans_we),
        .waddr (trans_waddr),
        .wdata (row_wdata),
        .raddr (trans_raddr),
        .rdata (trans_q)
    );

    nfabm_ram #(
        .WIDTH (N),
        .DEPTH (N)
    ) u_eps_ram (
        .aclk  (aclk),
        .we    (eps_we),
        .waddr (s_data.row_index[SW-1:0]),
        .wdata (row_wdata),
        .raddr (pick_idx),
        .rdata (eps_q)
    );

    // A read is never in flight across the change from gathering to closing,
    // so the current state tells which memory the returning row came from.
    always_comb begin
        if (!rvld_reg) begin
            rdata = '0;
        end else if (state_reg == ST_GATHER) begin
            rdata = trans_q;
        end else begin
            rdata = eps_q;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (s_data.req_type)
                        REQ_SYMBOL:  state_next = ST_GATHER;
                        REQ_RESTART: state_next = ST_CLOSE;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_GATHER: begin
                if (work_idle) begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if (work_idle) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs of the state machine.
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready  = 1'b1;
            ST_DONE: out_load = !m_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    // Active set and work list.
    always_comb begin
        cur_next  = cur_reg;
        work_next = work_reg;
        sym_next  = sym_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    sym_next = s_data.symbol;
                    case (s_data.req_type)
                        REQ_SYMBOL: begin
                            // The old set becomes the list to visit; the new set
                            // is built up from the rows that come back.
                            work_next = cur_reg;
                            cur_next  = '0;
                        end
                        REQ_RESTART: begin
                            if (start_ok) begin
                                cur_next = {{(N - 1){1'b0}}, 1'b1} << start_reg;
                            end else begin
                                cur_next = '0;
                            end
                            work_next = cur_next;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_GATHER: begin
                if (issue) begin
                    work_next = work_reg & ~pick_oh;
                end
                if (rd_pend_reg) begin
                    cur_next = cur_reg | rdata;
                end
                if (work_idle) begin
                    // Every gathered state still has to be expanded.
                    work_next = cur_reg;
                end
            end
            ST_CLOSE: begin
                // A state enters the work list only when it first becomes
                // active, so each row is read at most once.
                work_next = (work_reg & ~(issue ? pick_oh : '0)) |
                            (rd_pend_reg ? (rdata & ~cur_reg) : '0);
                cur_next  = cur_reg | (rd_pend_reg ? rdata : '0);
            end
            default: begin
            end
        endcase
    end

    // Result register.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next           = 1'b1;
            m_data_next.accepted   = |(cur_reg & final_mask_reg);
            m_data_next.active_set = SET_W'(cur_reg);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_reg        <= '0;
            work_reg       <= '0;
            sym_reg        <= 1'b0;
            rd_pend_reg    <= 1'b0;
            rvld_reg       <= 1'b0;
            trans_vld_reg  <= '0;
            eps_vld_reg    <= '0;
            m_valid_reg    <= 1'b0;
            final_mask_reg <= '0;
            start_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            work_reg    <= work_next;
            sym_reg     <= sym_next;
            rd_pend_reg <= issue;
            rvld_reg    <= rvld_next;
            m_valid_reg <= m_valid_next;
            if (trans_we) begin
                trans_vld_reg[trans_waddr] <= 1'b1;
            end
            if (eps_we) begin
                eps_vld_reg[s_data.row_index[SW-1:0]] <= 1'b1;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_FINAL_MASK:  final_mask_reg <= cfg_wdata[N-1:0];
                    CFG_START_STATE: start_reg      <= cfg_wdata[IDX_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> sim/tb_nfa_bitstream_matcher.sv
`default_nettype none

module tb_nfa_bitstream_matcher;
    import nfabm_pkg::*;

    localparam int NUM_ST       = NUM_STATES_DEF;
    localparam int MAX_GAP      = 17;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_CYCLES = 2 * NUM_ST + 16;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // Request codes the block has no use for; it must report the set unchanged.
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_MID = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI  = 3'd7;

    // States at or above NUM_ST never exist, so every row and set is cut to this mask.
    localparam logic [SET_W-1:0] LIVE_STATES =
        (NUM_ST >= SET_W) ? {SET_W{1'b1}} : ((64'd1 << NUM_ST) - 64'd1);

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    nfabm_in_t             s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    nfabm_out_t            m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    nfa_bitstream_matcher #(
        .NUM_STATES(NUM_ST)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Our own copy of the automaton: successor rows per state for each move kind,
    // the active set, and the two configuration registers.
    logic [SET_W-1:0] on_zero [0:63];
    logic [SET_W-1:0] on_one  [0:63];
    logic [SET_W-1:0] on_eps  [0:63];
    logic [SET_W-1:0] active_states;
    logic [SET_W-1:0] accept_mask;
    logic [IDX_W-1:0] restart_state;

    // Input transactions still to be offered, and the results we are waiting for.
    nfabm_in_t  stream_items  [$];
    nfabm_out_t expected_sets [$];
    nfabm_out_t want;

    int unsigned items_sent    = 0;
    int unsigned items_taken   = 0;
    int unsigned results_taken = 0;
    int unsigned results_seen  = 0;
    int unsigned hold_asked    = 0;
    int unsigned hold_granted  = 0;
    int unsigned cycles        = 0;
    int          mismatches    = 0;
    int          gap_left      = 0;
    int          stall_left    = 0;
    int          hold_left     = 0;
    int          rx_draw       = 0;
    int          random_done   = 0;
    bit          tx_idle_on    = 1'b1;
    bit          rx_idle_on    = 1'b1;

    // Union of the chosen rows over every state in the set. The selector reuses the
    // load codes: zero row, one row, epsilon row.
    function automatic logic [SET_W-1:0] rows_of(input logic [REQ_W-1:0] which,
                                                 input logic [SET_W-1:0] set);
        logic [SET_W-1:0] acc;
        acc = '0;
        for (int s = 0; s < SET_W; s++) begin
            if (set[s]) begin
                case (which)
                    REQ_LOAD_ZERO: acc |= on_zero[s];
                    REQ_LOAD_ONE:  acc |= on_one[s];
                    default:       acc |= on_eps[s];
                endcase
            end
        end
        return acc & LIVE_STATES;
    endfunction

    // Grow the set along epsilon rows until nothing new is reached.
    function automatic logic [SET_W-1:0] eps_close(input logic [SET_W-1:0] set);
        logic [SET_W-1:0] reach;
        logic [SET_W-1:0] grown;
        reach = set & LIVE_STATES;
        for (int n = 0; n <= SET_W; n++) begin
            grown = reach | rows_of(REQ_LOAD_EPS, reach);
            if (grown == reach) break;
            reach = grown;
        end
        return reach;
    endfunction

    // Apply one accepted transaction to our automaton and queue the result it must give.
    function automatic void advance_automaton(input nfabm_in_t item);
        nfabm_out_t res;
        case (item.req_type)
            REQ_LOAD_ZERO: begin
                if (item.row_index < NUM_ST) on_zero[item.row_index] = item.row_bits & LIVE_STATES;
            end
            REQ_LOAD_ONE: begin
                if (item.row_index < NUM_ST) on_one[item.row_index] = item.row_bits & LIVE_STATES;
            end
            REQ_LOAD_EPS: begin
                if (item.row_index < NUM_ST) on_eps[item.row_index] = item.row_bits & LIVE_STATES;
            end
            REQ_RESTART: begin
                if (restart_state < NUM_ST) begin
                    active_states = eps_close(64'd1 << restart_state);
                end else begin
                    active_states = '0;
                end
            end
            REQ_SYMBOL: begin
                active_states = eps_close(rows_of(item.symbol ? REQ_LOAD_ONE : REQ_LOAD_ZERO,
                                                  active_states));
            end
            default: begin
            end
        endcase
        res.accepted   = |(active_states & accept_mask);
        res.active_set = active_states;
        expected_sets  = {expected_sets, res};
    endfunction

    function automatic logic [SET_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic bit rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    // A row with a few successors, all inside the window of states in use.
    function automatic logic [SET_W-1:0] sparse_row(input int base, input int span,
                                                    input int max_bits);
        logic [SET_W-1:0] row;
        int n;
        row = '0;
        n = $urandom_range(0, max_bits);
        for (int k = 0; k < n; k++) row[base + $urandom_range(0, span - 1)] = 1'b1;
        return row;
    endfunction

    function automatic void add_item(input logic [REQ_W-1:0] req, input int idx,
                                     input logic [SET_W-1:0] bits, input bit sym);
        nfabm_in_t item;
        item.req_type  = req;
        item.row_index = idx[IDX_W-1:0];
        item.row_bits  = bits;
        item.symbol    = sym;
        stream_items   = {stream_items, item};
    endfunction

    // The block is idle once every item has been taken and every result has come back;
    // each transaction yields exactly one result, so nothing can still be in flight.
    task automatic wait_idle();
        while (stream_items.size() != 0 || items_sent != items_taken || expected_sets.size() != 0)
            @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // One random phase: new registers, a freshly loaded automaton confined to a window
    // of states, a restart, and then a run of symbols sprinkled with restarts and noise.
    task automatic random_phase(input int phase_no);
        int span;
        int base;
        int run_len;
        int pick;
        int st;
        logic [SET_W-1:0]      fmask;
        logic [CFG_DATA_W-1:0] sdata;
        wait_idle();
        span = (phase_no == 5) ? SET_W : $urandom_range(2, 12);
        base = $urandom_range(0, SET_W - span);
        case ((phase_no < 2) ? phase_no : $urandom_range(0, 3))
            0:       fmask = '0;
            1:       fmask = '1;
            2:       fmask = rand64();
            default: fmask = sparse_row(base, span, 3);
        endcase
        cfg_write(CFG_FINAL_MASK, fmask);
        case ($urandom_range(0, 5))
            0:       st = 0;
            1:       st = SET_W - 1;
            default: st = base + $urandom_range(0, span - 1);
        endcase
        // Upper bits of the write data are not part of the register; they get junk at times.
        sdata = $urandom_range(0, 1) ? rand64() : '0;
        sdata[IDX_W-1:0] = st[IDX_W-1:0];
        cfg_write(CFG_START_STATE, sdata);

        @(posedge aclk);
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        // Second phase: the receiver blocks for a long time while the sender keeps
        // pushing, so the result register and the input both back up.
        if (phase_no == 1) hold_asked++;

        for (int s = base; s < base + span; s++) begin
            add_item(REQ_LOAD_ZERO, s, sparse_row(base, span, 2), rbit());
            add_item(REQ_LOAD_ONE, s, sparse_row(base, span, 2), rbit());
            if (rbit()) begin
                add_item(REQ_LOAD_EPS, s, sparse_row(base, span, 1), rbit());
            end
        end
        add_item(REQ_RESTART, $urandom_range(0, 63), rand64(), rbit());
        run_len = $urandom_range(20, 50);
        for (int k = 0; k < run_len; k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                add_item(REQ_RESTART, $urandom_range(0, 63), rand64(), rbit());
            end else if (pick <= 2) begin
                add_item(REQ_W'($urandom_range(REQ_LOAD_ZERO, REQ_UNUSED_HI)),
                         $urandom_range(0, 63), rand64(), rbit());
            end else begin
                add_item(REQ_SYMBOL, $urandom_range(0, 63), rand64(), rbit());
            end
        end
        random_done += stream_items.size();
    endtask

    // Sender: a fresh transaction is put up on the falling edge once the previous one
    // has been taken and its drawn gap has run out. Valid stays high straight into
    // the next item when there is no gap.
    always @(negedge aclk) begin : drive_items
        if (!s_valid || items_taken == items_sent) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (aresetn && stream_items.size() != 0) begin
                s_data   <= stream_items.pop_front();
                s_valid  <= 1'b1;
                items_sent++;
                gap_left <= tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end else begin
                s_valid  <= 1'b0;
            end
        end
    end

    // Receiver: after every result it takes, it may stall for a drawn number of cycles.
    // A requested long hold takes priority and is counted down here.
    always @(negedge aclk) begin : drive_ready
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_granted != hold_asked) begin
            hold_granted++;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (results_seen != results_taken) begin
            results_seen = results_taken;
            rx_draw = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (rx_draw != 0) begin
                stall_left <= rx_draw - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready    <= 1'b1;
            end
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Scoreboard. The result is checked before the newly accepted item is predicted,
    // so a result leaving on the same edge is matched against older expectations.
    always @(posedge aclk) begin : score_results
        if (aresetn) begin
            if (cfg_we) begin
                if (cfg_index == CFG_FINAL_MASK) begin
                    accept_mask = cfg_wdata;
                end else if (cfg_index == CFG_START_STATE) begin
                    restart_state = cfg_wdata[IDX_W-1:0];
                end
            end
            if (m_valid && m_ready) begin
                results_taken++;
                if (expected_sets.size() == 0) begin
                    $error("unexpected result: active_set %h, accepted %0d",
                           m_data.active_set, m_data.accepted);
                    mismatches++;
                end else begin
                    want = expected_sets.pop_front();
                    if (want.accepted !== m_data.accepted) begin
                        $error("accepted: expected %0d, actual %0d",
                               want.accepted, m_data.accepted);
                        mismatches++;
                    end
                    if (want.active_set !== m_data.active_set) begin
                        $error("active_set: expected %h, actual %h",
                               want.active_set, m_data.active_set);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                items_taken++;
                advance_automaton(s_data);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : run_test
        int phase_no;
        for (int i = 0; i < 64; i++) begin
            on_zero[i] = '0;
            on_one[i]  = '0;
            on_eps[i]  = '0;
        end
        active_states = '0;
        accept_mask   = '0;
        restart_state = '0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, first under the reset registers: nothing accepting, start
        // state 0, and all rows empty.
        add_item(REQ_SYMBOL, 0, '0, 1'b0);               // step from the empty set
        add_item(REQ_RESTART, 0, '0, 1'b0);              // closure of a lone state
        add_item(REQ_UNUSED_LO, 63, '1, 1'b1);
        add_item(REQ_UNUSED_MID, 0, '0, 1'b0);
        add_item(REQ_UNUSED_HI, 42, rand64(), 1'b1);
        add_item(REQ_LOAD_ZERO, 0, '1, 1'b1);            // state 0 reaches every state on 0
        add_item(REQ_LOAD_EPS, 0, 64'd1 << 1, 1'b0);
        add_item(REQ_LOAD_EPS, 1, 64'd1 << 63, 1'b0);
        add_item(REQ_LOAD_EPS, 63, 64'd1, 1'b0);         // epsilon loop 0 -> 1 -> 63 -> 0
        add_item(REQ_RESTART, 0, '0, 1'b0);
        add_item(REQ_SYMBOL, 0, '0, 1'b1);               // no one rows: set becomes empty
        add_item(REQ_RESTART, 0, '0, 1'b0);
        add_item(REQ_SYMBOL, 0, '0, 1'b0);               // full set
        add_item(REQ_LOAD_ONE, 63, 64'd1 << 63, 1'b1);   // a load leaves the set alone
        add_item(REQ_SYMBOL, 63, '1, 1'b1);
        wait_idle();

        // Every state accepting; start at the top state, with junk in the upper data bits.
        cfg_write(CFG_FINAL_MASK, '1);
        cfg_write(CFG_START_STATE, '1);
        add_item(REQ_RESTART, 0, '0, 1'b0);
        add_item(REQ_SYMBOL, 0, '0, 1'b1);
        add_item(REQ_LOAD_EPS, 63, '0, 1'b0);            // break the epsilon loop
        add_item(REQ_SYMBOL, 0, '0, 1'b1);
        add_item(REQ_LOAD_ZERO, 0, '0, 1'b0);
        add_item(REQ_SYMBOL, 0, '0, 1'b0);               // top state has no zero row
        wait_idle();

        // Random part. Each phase starts only after the previous one has fully
        // drained, which also gives the sender its pause until all results are in.
        phase_no = 0;
        while (random_done < RANDOM_ITEMS) begin
            random_phase(phase_no);
            phase_no++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && expected_sets.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/nfabm_pkg.sv
rtl/nfabm_ram.sv
rtl/nfa_bitstream_matcher.sv
sim/tb_nfa_bitstream_matcher.sv
